// ===== hdl/lfspg_pkg.sv =====
package lfspg_pkg;

  // Field widths fixed by the item formats.
  localparam int COLOR_W     = 24;
  localparam int LED_COUNT_W = 6;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // Request codes.
  localparam logic [1:0] REQ_CLEAR     = 2'd0;
  localparam logic [1:0] REQ_WRITE_ONE = 2'd1;
  localparam logic [1:0] REQ_WRITE_ALL = 2'd2;
  localparam logic [1:0] REQ_ESTIMATE  = 2'd3;

  // Battery codes; anything at or above empty counts as empty.
  localparam logic [1:0] BATT_LOW   = 2'd1;
  localparam logic [1:0] BATT_EMPTY = 2'd2;

  // Power events reported in the status item.
  localparam logic [1:0] EVT_NONE = 2'd0;
  localparam logic [1:0] EVT_ON   = 2'd1;
  localparam logic [1:0] EVT_OFF  = 2'd2;

  // Result kinds.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  // Register map.
  localparam logic [PADDR_W-1:0] ADDR_LED_COUNT = 3'd0;

  // Current estimate in nA, then divided down to mA.
  localparam int ACC_W       = 29;
  localparam int NA_PER_LED  = 741000;
  localparam int NA_PER_UNIT = 18200;
  localparam int NA_BASE     = 7100000;
  localparam int NA_PER_MA   = 1000000;
  localparam logic [7:0] MA_SAT = 8'd255;

  // Reciprocal of one million scaled by 2^49 and rounded up. Multiplying a
  // total below 2^29 by it and dropping 49 bits gives the exact quotient.
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 49;
  localparam int PROD_W      = ACC_W + RECIP_W;
  localparam logic [RECIP_W-1:0] NA_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(NA_PER_MA) - 64'd1) / 64'(NA_PER_MA));

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        pixel_index;
    logic [COLOR_W-1:0] color;
    logic               defer_show;
    logic [1:0]         battery_level;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [4:0]         pixel_out_index;
    logic [COLOR_W-1:0] pixel_out_color;
    logic               last;
    logic               power_on;
    logic [1:0]         power_event;
    logic [7:0]         current_ma;
  } out_item_t;

  // Low-battery dimming of one channel: ceil(x / 32).
  function automatic logic [7:0] dim_chan(input logic [7:0] x);
    logic [8:0] t;
    t = {1'b0, x} + 9'd31;
    return {4'b0000, t[8:5]};
  endfunction

  function automatic logic [COLOR_W-1:0] dim_color(input logic [COLOR_W-1:0] c);
    return {dim_chan(c[23:16]), dim_chan(c[15:8]), dim_chan(c[7:0])};
  endfunction

endpackage

// ===== hdl/lfspg_mem.sv =====
// Pixel store: one write port, one registered read port, and a valid bit
// per entry so that reset and the clear request empty it at once.
// An entry whose valid bit is low reads as black.
module lfspg_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [lfspg_pkg::COLOR_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [lfspg_pkg::COLOR_W-1:0] rdata
);

  logic [lfspg_pkg::COLOR_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]              vld_r;
  logic [lfspg_pkg::COLOR_W-1:0] rdata_r;
  logic                          rvld_r;

  // Storage array, no reset.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Valid bits: cleared together, set by each write.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else if (re) begin
      rvld_r <= vld_r[raddr];
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

// ===== hdl/led_frame_store_power_gate.sv =====
// LED frame store with supply gating. One item is taken at a time; with n the
// effective LED count (led_count, capped at MAX_LEDS), a show scans the store
// for a lit pixel, then streams each pixel in two steps (store read, then dim,
// write back and hand over), leaves the stream and sends the status item. A
// write-all request first writes the colour to all n store entries. A current
// estimate runs the scan, multiplies the nA total by a fixed-point reciprocal of
// one million and sends the status item. The scan reads the pixel store one entry
// per cycle through its registered read port, and every pass walks the store in
// order, so the time taken grows with n. Stalls on the result side lengthen the
// stream and the status item.
module led_frame_store_power_gate #(
  parameter int MAX_LEDS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lfspg_pkg::in_item_t                 in_data,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output lfspg_pkg::out_item_t                out_data,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lfspg_pkg::PADDR_W-1:0]       paddr,
  input  logic [lfspg_pkg::PDATA_W-1:0]       pwdata,
  output logic [lfspg_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = $clog2(MAX_LEDS + 1);
  localparam logic [lfspg_pkg::LED_COUNT_W-1:0] MAX_N =
    lfspg_pkg::LED_COUNT_W'(MAX_LEDS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FILL   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_STR_RD = 3'd4;
  localparam logic [2:0] ST_STR_WR = 3'd5;
  localparam logic [2:0] ST_STATUS = 3'd6;

  logic [2:0]                          state_r, state_nxt;
  logic [CW-1:0]                       cnt_r, cnt_nxt;
  logic [CW-1:0]                       n_r, n_nxt;
  logic [1:0]                          req_r, req_nxt;
  logic [1:0]                          batt_r, batt_nxt;
  logic [lfspg_pkg::COLOR_W-1:0]       col_r, col_nxt;
  logic                                supply_r, supply_nxt;
  logic [1:0]                          evt_r, evt_nxt;
  logic [7:0]                          ma_r, ma_nxt;
  logic                                nz_r, nz_nxt;
  logic                                pend_r, pend_nxt;
  logic [lfspg_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic [lfspg_pkg::ACC_W-1:0]         rem_r, rem_nxt;
  logic                                out_valid_r, out_valid_nxt;
  lfspg_pkg::out_item_t                out_data_r, out_data_nxt;
  logic [lfspg_pkg::LED_COUNT_W-1:0]   led_count_r, led_count_nxt;

  logic                                mem_clr;
  logic                                mem_we;
  logic [AW-1:0]                       mem_waddr;
  logic [lfspg_pkg::COLOR_W-1:0]       mem_wdata;
  logic                                mem_re;
  logic [AW-1:0]                       mem_raddr;
  logic [lfspg_pkg::COLOR_W-1:0]       pix;

  logic [lfspg_pkg::LED_COUNT_W-1:0]   n_now;
  logic [lfspg_pkg::COLOR_W-1:0]       pix_dim;
  logic [9:0]                          chan_sum;
  logic [lfspg_pkg::ACC_W-1:0]         led_term;
  logic [lfspg_pkg::PROD_W-1:0]        quot_prod;
  logic [9:0]                          quot;
  logic                                slot_free;
  logic                                cfg_wr;

  lfspg_mem #(
    .DEPTH (MAX_LEDS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (mem_clr),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (pix)
  );

  // Configuration register access.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr == lfspg_pkg::ADDR_LED_COUNT) ?
                  lfspg_pkg::PDATA_W'(led_count_r) : '0;

  always_comb begin
    led_count_nxt = led_count_r;
    if (cfg_wr && paddr == lfspg_pkg::ADDR_LED_COUNT) begin
      led_count_nxt = pwdata[lfspg_pkg::LED_COUNT_W-1:0];
    end
  end

  // Per-pixel arithmetic on the store read data.
  assign n_now    = (led_count_r > MAX_N) ? MAX_N : led_count_r;
  assign pix_dim  = lfspg_pkg::dim_color(pix);
  assign chan_sum = 10'(pix[23:16]) + 10'(pix[15:8]) + 10'(pix[7:0]);
  assign led_term = lfspg_pkg::ACC_W'(lfspg_pkg::NA_PER_LED) +
                    lfspg_pkg::ACC_W'(chan_sum) *
                    lfspg_pkg::ACC_W'(lfspg_pkg::NA_PER_UNIT);

  // The nA total in mA, truncated, by multiplying with the scaled reciprocal.
  assign quot_prod = lfspg_pkg::PROD_W'(rem_r) * lfspg_pkg::PROD_W'(lfspg_pkg::NA_RECIP);
  assign quot      = quot_prod[lfspg_pkg::RECIP_SHIFT +: 10];

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Request sequencer.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    req_nxt       = req_r;
    batt_nxt      = batt_r;
    col_nxt       = col_r;
    supply_nxt    = supply_r;
    evt_nxt       = evt_r;
    ma_nxt        = ma_r;
    nz_nxt        = nz_r;
    pend_nxt      = pend_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_clr       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt    = CW'(n_now);
          req_nxt  = in_data.req_type;
          batt_nxt = in_data.battery_level;
          col_nxt  = in_data.color;
          evt_nxt  = lfspg_pkg::EVT_NONE;
          ma_nxt   = '0;
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
          nz_nxt   = 1'b0;
          acc_nxt  = '0;
          unique case (in_data.req_type)
            lfspg_pkg::REQ_CLEAR: begin
              mem_clr   = 1'b1;
              state_nxt = ST_SCAN;
            end
            lfspg_pkg::REQ_WRITE_ONE: begin
              if (in_data.pixel_index < 16'(n_now)) begin
                mem_we    = 1'b1;
                mem_waddr = in_data.pixel_index[AW-1:0];
                mem_wdata = in_data.color;
                state_nxt = in_data.defer_show ? ST_STATUS : ST_SCAN;
              end else begin
                state_nxt = ST_STATUS;
              end
            end
            lfspg_pkg::REQ_WRITE_ALL: begin
              state_nxt = ST_FILL;
            end
            lfspg_pkg::REQ_ESTIMATE: begin
              state_nxt = ST_SCAN;
            end
          endcase
        end
      end

      // Write the request colour to every pixel in use.
      ST_FILL: begin
        if (cnt_r < n_r) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r[AW-1:0];
          mem_wdata = col_r;
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end

      // Pipelined pass over the store: lit check and current sum.
      ST_SCAN: begin
        pend_nxt = (cnt_r < n_r);
        if (cnt_r < n_r) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_r[AW-1:0];
          cnt_nxt   = cnt_r + 1'b1;
        end
        if (pend_r && pix != '0) begin
          nz_nxt  = 1'b1;
          acc_nxt = acc_r + led_term;
        end
        if (cnt_r == n_r && !pend_r) begin
          cnt_nxt = '0;
          if (req_r == lfspg_pkg::REQ_ESTIMATE) begin
            rem_nxt   = acc_r + (nz_r ? lfspg_pkg::ACC_W'(lfspg_pkg::NA_BASE) : '0);
            state_nxt = ST_DIV;
          end else if (!nz_r) begin
            if (supply_r) begin
              supply_nxt = 1'b0;
              evt_nxt    = lfspg_pkg::EVT_OFF;
            end
            state_nxt = ST_STATUS;
          end else if (batt_r >= lfspg_pkg::BATT_EMPTY) begin
            state_nxt = ST_STATUS;
          end else begin
            if (!supply_r) begin
              supply_nxt = 1'b1;
              evt_nxt    = lfspg_pkg::EVT_ON;
            end
            state_nxt = ST_STR_RD;
          end
        end
      end

      // Saturate the quotient of the nA total by one million.
      ST_DIV: begin
        ma_nxt    = (quot > 10'(lfspg_pkg::MA_SAT)) ? lfspg_pkg::MA_SAT : quot[7:0];
        state_nxt = ST_STATUS;
      end

      // Stream: read one pixel.
      ST_STR_RD: begin
        if (cnt_r < n_r) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_r[AW-1:0];
          state_nxt = ST_STR_WR;
        end else begin
          state_nxt = ST_STATUS;
        end
      end

      // Stream: dim and write back at low battery, then send the pixel.
      ST_STR_WR: begin
        if (slot_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.kind            = lfspg_pkg::KIND_PIXEL;
          out_data_nxt.pixel_out_index = 5'(cnt_r[AW-1:0]);
          out_data_nxt.pixel_out_color = (batt_r == lfspg_pkg::BATT_LOW) ? pix_dim : pix;
          out_data_nxt.last            = 1'b0;
          out_data_nxt.power_on        = supply_r;
          out_data_nxt.power_event     = lfspg_pkg::EVT_NONE;
          out_data_nxt.current_ma      = '0;
          if (batt_r == lfspg_pkg::BATT_LOW) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[AW-1:0];
            mem_wdata = pix_dim;
          end
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_STR_RD;
        end
      end

      // Closing status item.
      ST_STATUS: begin
        if (slot_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.kind            = lfspg_pkg::KIND_STATUS;
          out_data_nxt.pixel_out_index = '0;
          out_data_nxt.pixel_out_color = '0;
          out_data_nxt.last            = 1'b1;
          out_data_nxt.power_on        = supply_r;
          out_data_nxt.power_event     = evt_r;
          out_data_nxt.current_ma      = ma_r;
          state_nxt                    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      supply_r    <= 1'b0;
      out_valid_r <= 1'b0;
      led_count_r <= '0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      supply_r    <= supply_nxt;
      out_valid_r <= out_valid_nxt;
      led_count_r <= led_count_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    req_r      <= req_nxt;
    batt_r     <= batt_nxt;
    col_r      <= col_nxt;
    evt_r      <= evt_nxt;
    ma_r       <= ma_nxt;
    nz_r       <= nz_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== tb/led_frame_checker.sv =====
`timescale 1ns / 100ps

module led_frame_checker #(
  parameter int MAX_LEDS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  lfspg_pkg::in_item_t             in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  lfspg_pkg::out_item_t            out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [lfspg_pkg::PADDR_W-1:0]   paddr,
  input  logic [lfspg_pkg::PDATA_W-1:0]   pwdata,
  input  logic [lfspg_pkg::PDATA_W-1:0]   prdata,
  output int                              mismatch_count,
  output int                              results_pending,
  output int                              results_checked
);

  // Current model in nA, kept apart from the design's own constants.
  localparam int unsigned LED_NA    = 741000;
  localparam int unsigned UNIT_NA   = 18200;
  localparam int unsigned BASE_NA   = 7100000;
  localparam int unsigned NA_IN_MA  = 1000000;
  localparam int unsigned DIM_STEP  = 32;
  localparam int unsigned MA_CEIL   = 255;

  // Shadow copy of the frame store, the supply flag and the chain length.
  logic [lfspg_pkg::COLOR_W-1:0]     frame [MAX_LEDS];
  logic                              supply;
  logic [lfspg_pkg::LED_COUNT_W-1:0] chain_len;
  lfspg_pkg::out_item_t              awaited_results [$];
  int                                bad_results;
  int                                seen_results;

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
    results_checked = 0;
    bad_results     = 0;
    seen_results    = 0;
    supply          = 1'b0;
    chain_len       = '0;
    for (int i = 0; i < MAX_LEDS; i++) frame[i] = '0;
  end

  // Number of pixels on the chain; anything above the store size is capped.
  function automatic int chain_span();
    return (chain_len > MAX_LEDS) ? MAX_LEDS : int'(chain_len);
  endfunction

  // Low-battery dimming: each channel becomes its value divided by 32, rounded up.
  function automatic logic [lfspg_pkg::COLOR_W-1:0] dimmed(
      input logic [lfspg_pkg::COLOR_W-1:0] c);
    logic [lfspg_pkg::COLOR_W-1:0] d;
    int                            ch;
    for (ch = 0; ch < 3; ch++) begin
      d[8*ch +: 8] = 8'((int'(c[8*ch +: 8]) + DIM_STEP - 1) / DIM_STEP);
    end
    return d;
  endfunction

  // Estimated LED current in mA over the pixels in use, saturated.
  function automatic logic [7:0] current_estimate();
    longint unsigned na;
    int              lit;
    int              units;
    int              i;
    na  = 0;
    lit = 0;
    for (i = 0; i < chain_span(); i++) begin
      if (frame[i] != '0) begin
        units = int'(frame[i][23:16]) + int'(frame[i][15:8]) + int'(frame[i][7:0]);
        lit++;
        na += LED_NA + UNIT_NA * units;
      end
    end
    if (lit > 0) na += BASE_NA;
    na = na / NA_IN_MA;
    return (na > MA_CEIL) ? 8'(MA_CEIL) : 8'(na);
  endfunction

  // Show step: power gating, optional dimming, then the streamed pixel items.
  task automatic run_show(input logic [1:0] batt, output logic [1:0] evt);
    lfspg_pkg::out_item_t px;
    bit                   any_lit;
    int                   i;
    evt     = lfspg_pkg::EVT_NONE;
    any_lit = 1'b0;
    for (i = 0; i < chain_span(); i++) begin
      if (frame[i] != '0) any_lit = 1'b1;
    end
    if (!any_lit) begin
      if (supply) begin
        supply = 1'b0;
        evt    = lfspg_pkg::EVT_OFF;
      end
    end else if (batt < lfspg_pkg::BATT_EMPTY) begin
      if (!supply) begin
        supply = 1'b1;
        evt    = lfspg_pkg::EVT_ON;
      end
      for (i = 0; i < chain_span(); i++) begin
        if (batt == lfspg_pkg::BATT_LOW) frame[i] = dimmed(frame[i]);
        px                 = '0;
        px.kind            = lfspg_pkg::KIND_PIXEL;
        px.pixel_out_index = i[4:0];
        px.pixel_out_color = frame[i];
        px.power_on        = supply;
        awaited_results.push_back(px);
      end
    end
  endtask

  // Works out every result item that one accepted request should produce.
  task automatic apply_request(input lfspg_pkg::in_item_t req);
    lfspg_pkg::out_item_t status;
    logic [1:0]           evt;
    logic [7:0]           ma;
    int                   i;
    evt = lfspg_pkg::EVT_NONE;
    ma  = '0;
    case (req.req_type)
      lfspg_pkg::REQ_CLEAR: begin
        for (i = 0; i < MAX_LEDS; i++) frame[i] = '0;
        run_show(req.battery_level, evt);
      end
      lfspg_pkg::REQ_WRITE_ONE: begin
        if (int'(req.pixel_index) < chain_span()) begin
          frame[req.pixel_index] = req.color;
          if (!req.defer_show) run_show(req.battery_level, evt);
        end
      end
      lfspg_pkg::REQ_WRITE_ALL: begin
        for (i = 0; i < chain_span(); i++) frame[i] = req.color;
        run_show(req.battery_level, evt);
      end
      default: begin
        ma = current_estimate();
      end
    endcase
    status             = '0;
    status.kind        = lfspg_pkg::KIND_STATUS;
    status.last        = 1'b1;
    status.power_on    = supply;
    status.power_event = evt;
    status.current_ma  = ma;
    awaited_results.push_back(status);
  endtask

  // Reports one differing field; returns 1 when it differs.
  function automatic bit field_bad(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
    if (got === want) return 1'b0;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    return 1'b1;
  endfunction

  // Channel monitor: results first, then register traffic, then new requests.
  always @(posedge clk) begin
    lfspg_pkg::out_item_t want;
    bit                   bad;
    if (!rst_n) begin
      for (int i = 0; i < MAX_LEDS; i++) frame[i] = '0;
      supply    = 1'b0;
      chain_len = '0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen_results++;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result item, got %p", $time, out_data);
          bad_results++;
        end else begin
          want = awaited_results.pop_front();
          bad  = field_bad("kind", want.kind, out_data.kind)
               | field_bad("pixel_out_index", want.pixel_out_index,
                           out_data.pixel_out_index)
               | field_bad("pixel_out_color", want.pixel_out_color,
                           out_data.pixel_out_color)
               | field_bad("last", want.last, out_data.last)
               | field_bad("power_on", want.power_on, out_data.power_on)
               | field_bad("power_event", want.power_event, out_data.power_event)
               | field_bad("current_ma", want.current_ma, out_data.current_ma);
          if (bad) bad_results++;
        end
      end
      if (psel && penable && pready && paddr == lfspg_pkg::ADDR_LED_COUNT) begin
        if (pwrite) begin
          chain_len = pwdata[lfspg_pkg::LED_COUNT_W-1:0];
        end else if (prdata !== lfspg_pkg::PDATA_W'(chain_len)) begin
          $display("%0t: led_count read-back mismatch, expected 0x%0h, got 0x%0h",
                   $time, chain_len, prdata);
          bad_results++;
        end
      end
      if (in_valid && in_ready) apply_request(in_data);
    end
    mismatch_count  <= bad_results;
    results_pending <= awaited_results.size();
    results_checked <= seen_results;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int         MAX_LEDS        = 32;
  localparam int         DRAIN_LIMIT     = 50000;
  localparam int         SETTLE_CYCLES   = 3 * MAX_LEDS + 24;
  localparam int         ITEMS_PER_PHASE = 50;
  localparam logic [1:0] BATT_NORMAL     = 2'd0;
  localparam logic [1:0] BATT_CODE_THREE = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  lfspg_pkg::in_item_t             in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  lfspg_pkg::out_item_t            out_data;
  logic                            psel      = 1'b0;
  logic                            penable   = 1'b0;
  logic                            pwrite    = 1'b0;
  logic [lfspg_pkg::PADDR_W-1:0]   paddr     = '0;
  logic [lfspg_pkg::PDATA_W-1:0]   pwdata    = '0;
  logic [lfspg_pkg::PDATA_W-1:0]   prdata;
  logic                            pready;

  int mismatch_count;
  int results_pending;
  int results_checked;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int chain_setting  = 0;
  int requests_sent  = 0;
  int settings_used  = 0;

  always #5 clk = ~clk;

  led_frame_store_power_gate #(.MAX_LEDS(MAX_LEDS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  led_frame_checker #(.MAX_LEDS(MAX_LEDS)) frame_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending),
    .results_checked(results_checked)
  );

  // Result side back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Safety net against a hung handshake.
  initial begin
    #20000000;
    $display("%0t: run timed out", $time);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic set_idle(input idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 75 : (mode == IDLE_BOTH) ? 8 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 75 : (mode == IDLE_BOTH) ? 8 : 0;
  endtask

  // Offers one request item; valid stays up between back-to-back items.
  task automatic send_item(input lfspg_pkg::in_item_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      if (in_valid) in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Holds the request side quiet until every predicted result has been seen or the drain guard runs out.
  task automatic wait_for_results();
    int guard;
    guard = 0;
    if (in_valid) in_valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (results_pending != 0 && guard < DRAIN_LIMIT);
  endtask

  // Register write followed by a read-back, both as setup and access cycles.
  task automatic program_led_count(input int value);
    paddr   <= lfspg_pkg::ADDR_LED_COUNT;
    pwdata  <= lfspg_pkg::PDATA_W'(value);
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk) penable <= 1'b1;
    @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk) penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    chain_setting = value;
    settings_used++;
  endtask

  function automatic lfspg_pkg::in_item_t make_req(
      input logic [1:0] kind, input int index,
      input logic [lfspg_pkg::COLOR_W-1:0] color,
      input logic defer, input logic [1:0] batt);
    lfspg_pkg::in_item_t req;
    req.req_type      = kind;
    req.pixel_index   = 16'(index);
    req.color         = color;
    req.defer_show    = defer;
    req.battery_level = batt;
    return req;
  endfunction

  // Random request: mostly in-range pixel writes and estimates, so frames
  // build up, light up, dim and switch off again.
  function automatic lfspg_pkg::in_item_t random_request();
    lfspg_pkg::in_item_t req;
    int                  span;
    int                  pick;
    span = (chain_setting > MAX_LEDS) ? MAX_LEDS : chain_setting;
    pick = $urandom_range(99);
    if (pick < 8)       req.req_type = lfspg_pkg::REQ_CLEAR;
    else if (pick < 55) req.req_type = lfspg_pkg::REQ_WRITE_ONE;
    else if (pick < 70) req.req_type = lfspg_pkg::REQ_WRITE_ALL;
    else                req.req_type = lfspg_pkg::REQ_ESTIMATE;
    if (span > 0 && $urandom_range(9) < 8) req.pixel_index = 16'($urandom_range(span - 1));
    else                                   req.pixel_index = 16'($urandom_range(16'hFFFF));
    case ($urandom_range(5))
      0:       req.color = '0;
      1:       req.color = 24'hFFFFFF;
      2:       req.color = {8'($urandom_range(63)), 8'($urandom_range(63)),
                            8'($urandom_range(63))};
      default: req.color = 24'($urandom);
    endcase
    req.defer_show = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 50)      req.battery_level = BATT_NORMAL;
    else if (pick < 75) req.battery_level = lfspg_pkg::BATT_LOW;
    else if (pick < 90) req.battery_level = lfspg_pkg::BATT_EMPTY;
    else                req.battery_level = BATT_CODE_THREE;
    return req;
  endfunction

  initial begin
    int ph;
    int k;
    int setting;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idle(IDLE_NONE);

    // With the reset count of zero a lit frame still reads as dark.
    send_item(make_req(lfspg_pkg::REQ_WRITE_ALL, 0, 24'hFFFFFF, 1'b0, BATT_NORMAL));
    send_item(make_req(lfspg_pkg::REQ_ESTIMATE, 0, 24'h0, 1'b0, BATT_NORMAL));
    wait_for_results();

    // Short chain: power on and off, dimming, deferred and out-of-range writes.
    program_led_count(5);
    send_item(make_req(lfspg_pkg::REQ_WRITE_ALL, 0, 24'hFFFFFF, 1'b0, BATT_NORMAL));
    send_item(make_req(lfspg_pkg::REQ_ESTIMATE, 0, 24'h0, 1'b1, BATT_NORMAL));
    send_item(make_req(lfspg_pkg::REQ_WRITE_ALL, 0, 24'h000000, 1'b0, BATT_NORMAL));
    send_item(make_req(lfspg_pkg::REQ_WRITE_ONE, 0, 24'h123456, 1'b0,
                       lfspg_pkg::BATT_LOW));
    send_item(make_req(lfspg_pkg::REQ_WRITE_ONE, 4, 24'hFFFFFF, 1'b1, BATT_NORMAL));
    send_item(make_req(lfspg_pkg::REQ_WRITE_ONE, 5, 24'hABCDEF, 1'b0, BATT_NORMAL));
    send_item(make_req(lfspg_pkg::REQ_WRITE_ONE, 16'hFFFF, 24'h00FF00, 1'b0, BATT_NORMAL));
    send_item(make_req(lfspg_pkg::REQ_ESTIMATE, 0, 24'h0, 1'b0, BATT_NORMAL));
    send_item(make_req(lfspg_pkg::REQ_WRITE_ONE, 1, 24'h010203, 1'b0,
                       lfspg_pkg::BATT_EMPTY));
    send_item(make_req(lfspg_pkg::REQ_WRITE_ONE, 2, 24'h808080, 1'b0, BATT_CODE_THREE));
    send_item(make_req(lfspg_pkg::REQ_CLEAR, 0, 24'h0, 1'b1, BATT_NORMAL));
    send_item(make_req(lfspg_pkg::REQ_WRITE_ALL, 0, 24'h1F2021, 1'b1,
                       lfspg_pkg::BATT_LOW));
    send_item(make_req(lfspg_pkg::REQ_CLEAR, 0, 24'h0, 1'b0, lfspg_pkg::BATT_EMPTY));
    wait_for_results();

    // A count above the store size acts as a full chain; the estimate saturates.
    program_led_count(33);
    send_item(make_req(lfspg_pkg::REQ_WRITE_ALL, 0, 24'hFFFFFF, 1'b0, BATT_NORMAL));
    send_item(make_req(lfspg_pkg::REQ_ESTIMATE, 0, 24'h0, 1'b0, BATT_NORMAL));
    send_item(make_req(lfspg_pkg::REQ_WRITE_ONE, 31, 24'h000001, 1'b0, BATT_NORMAL));
    send_item(make_req(lfspg_pkg::REQ_WRITE_ONE, 32, 24'hFFFFFF, 1'b0, BATT_NORMAL));

    // Random phases over several chain lengths and every idling mode.
    for (ph = 0; ph < 8; ph++) begin
      wait_for_results();
      case (ph)
        0:       setting = 32;
        1:       setting = 7;
        2:       setting = 1;
        3:       setting = 63;
        4:       setting = 0;
        5:       setting = 33;
        6:       setting = $urandom_range(63);
        default: setting = 12;
      endcase
      program_led_count(setting);
      set_idle(idle_mode_e'(ph % 4));
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_item(random_request());
        if ($urandom_range(24) == 0) wait_for_results();
      end
    end
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (results_pending != 0) begin
      $display("%0t: %0d expected result items never arrived", $time, results_pending);
    end
    $display("Sent %0d requests across %0d chain-length settings, all battery codes",
             requests_sent, settings_used);
    $display("and four idling modes; %0d result items were compared.", results_checked);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
